FILE: rtl/msgbf_pkg.sv
// ----------------------------------------------------------------------------
// Message block framer - shared definitions
// Field widths, framing constants, reset values and the command format
// that the front end hands to the framing back end.
// ----------------------------------------------------------------------------
`default_nettype none

package msgbf_pkg;

    localparam int BLEN_W     = 17;     // block length / block position
    localparam int MLEN_W     = 16;     // message length / bytes outstanding
    localparam int BYTE_W     = 8;
    localparam int MIN_BLOCK  = 16;     // block lengths below this act as this
    localparam int MIN_ROOM   = 5;      // fewer bytes left at a message start: pad
    localparam int WORD_BYTES = 4;      // length and carry words are 4 bytes, LE

    localparam logic [BLEN_W-1:0] BLOCK_LEN_RST = 17'd1024;
    localparam logic [MLEN_W-1:0] MAX_MSG_RST   = 16'd1016;

    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic CFG_BLOCK_LEN = 1'b0;
    localparam logic CFG_MAX_MSG   = 1'b1;

    typedef enum logic [1:0] {
        OP_START,       // message start accepted
        OP_REJECT,      // message start with a length above the limit
        OP_DATA         // data byte, subject to bytes outstanding
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [MLEN_W-1:0] len;
        logic              dvalid;
        logic [BYTE_W-1:0] data;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/msgbf_front.sv
// ----------------------------------------------------------------------------
// Message block framer - front end
// Accepts input transactions, checks message lengths against the limit and
// turns each item into a framing command; items that carry nothing are
// consumed here.
// ----------------------------------------------------------------------------
`default_nettype none

module msgbf_front
    import msgbf_pkg::*;
(
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    input  wire logic [23:0]       i_s_data,      // msg_len[15:0], data_byte[23:16]
    input  wire logic [1:0]        i_s_user,      // starts_message[0], data_valid[1]
    input  wire logic [MLEN_W-1:0] i_max_msg_len,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic              w_starts;
    logic              w_dvalid;
    logic [MLEN_W-1:0] w_len;

    assign w_starts = i_s_user[0];
    assign w_dvalid = i_s_user[1];
    assign w_len    = i_s_data[15:0];

    assign o_s_ready = !i_q_full;

    // a continuation item without a byte never produces anything
    assign o_push = i_s_valid && !i_q_full && (w_starts || w_dvalid);

    always_comb begin
        o_cmd.len    = w_len;
        o_cmd.dvalid = w_dvalid;
        o_cmd.data   = i_s_data[23:16];
        if (w_starts) begin
            o_cmd.op = (w_len > i_max_msg_len) ? OP_REJECT : OP_START;
        end else begin
            o_cmd.op = OP_DATA;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/msgbf_queue.sv
// ----------------------------------------------------------------------------
// Message block framer - command queue
// Small register FIFO between front and back end; the head entry stays
// visible until the back end pops it.
// ----------------------------------------------------------------------------
`default_nettype none

module msgbf_queue
    import msgbf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt,  n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_SLOT) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_SLOT) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/msgbf_back.sv
// ----------------------------------------------------------------------------
// Message block framer - framing back end
// Sequences padding, block headers, length words, data bytes and rejections
// for the queue head, one result per cycle into an output register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module msgbf_back
    import msgbf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [BLEN_W-1:0] i_block_len,
    input  wire logic              i_cmd_valid,
    input  wire t_cmd              i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_out_end,
    output logic                   o_out_status,
    output logic                   o_out_last
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PAD  = 3'd1;   // zero fill to block end
    localparam logic [2:0] PH_HDR0 = 3'd2;   // block header, no carry
    localparam logic [2:0] PH_LEN  = 3'd3;   // message length word
    localparam logic [2:0] PH_HDR1 = 3'd4;   // block header with bytes outstanding
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_REJ  = 3'd6;
    localparam logic [2:0] PH_NONE = 3'd7;   // item consumed without result

    localparam logic [1:0]        BIDX_LAST = 2'(WORD_BYTES - 1);
    localparam logic [BLEN_W-1:0] MIN_BLK   = BLEN_W'(MIN_BLOCK);
    localparam logic [BLEN_W:0]   ROOM      = (BLEN_W+1)'(MIN_ROOM);

    function automatic logic [BYTE_W-1:0] word_byte(logic [MLEN_W-1:0] w, logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = w[7:0];
            2'd1:    b = w[15:8];
            default: b = '0;
        endcase
        return b;
    endfunction

    logic [2:0]        r_phase, n_phase;
    logic [1:0]        r_bidx,  n_bidx;
    logic [BLEN_W-1:0] r_pos,   n_pos;
    logic [MLEN_W-1:0] r_msg_left, n_msg_left;

    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_oend,  n_oend;
    logic              r_ostat, n_ostat;
    logic              r_olast, n_olast;

    logic              w_slot_free;
    logic              w_go;
    logic [BLEN_W-1:0] w_blen;
    logic [BLEN_W:0]   w_pos_inc;
    logic              w_blk_end;
    logic [BLEN_W-1:0] w_np;
    logic              w_room_small;
    logic [2:0]        w_entry;
    logic [2:0]        w_eph;
    logic              w_emit;
    logic              w_done;

    assign w_slot_free = !r_ovalid || i_out_ready;
    assign w_go        = i_cmd_valid && w_slot_free;

    assign w_blen       = (i_block_len < MIN_BLK) ? MIN_BLK : i_block_len;
    assign w_pos_inc    = {1'b0, r_pos} + 1'b1;
    assign w_blk_end    = (w_pos_inc >= {1'b0, w_blen});
    assign w_np         = w_blk_end ? '0 : w_pos_inc[BLEN_W-1:0];
    assign w_room_small = ({1'b0, r_pos} + ROOM) > {1'b0, w_blen};

    // first phase of a fresh command at the queue head
    always_comb begin
        case (i_cmd.op)
            OP_START: begin
                if (r_pos == '0) begin
                    w_entry = PH_HDR0;
                end else if (w_room_small) begin
                    w_entry = PH_PAD;
                end else begin
                    w_entry = PH_LEN;
                end
            end
            OP_REJECT: w_entry = PH_REJ;
            OP_DATA: begin
                if (r_msg_left == '0) begin
                    w_entry = PH_NONE;
                end else if (r_pos == '0) begin
                    w_entry = PH_HDR1;
                end else begin
                    w_entry = PH_DATA;
                end
            end
            default: w_entry = PH_NONE;
        endcase
    end

    assign w_eph = (r_phase == PH_IDLE) ? w_entry : r_phase;

    always_comb begin
        n_phase    = w_eph;
        n_bidx     = r_bidx;
        n_msg_left = r_msg_left;
        n_obyte    = '0;
        n_ostat    = 1'b0;
        w_emit     = 1'b1;
        w_done     = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_cmd.op == OP_START) begin
                n_msg_left = i_cmd.len;
            end else if (i_cmd.op == OP_REJECT) begin
                n_msg_left = '0;
            end
        end

        case (w_eph)
            PH_PAD: begin
                if (w_blk_end) begin
                    n_phase = PH_HDR0;
                end
            end
            PH_HDR0: begin
                if (r_bidx == BIDX_LAST) begin
                    n_phase = PH_LEN;
                    n_bidx  = '0;
                end else begin
                    n_bidx = r_bidx + 1'b1;
                end
            end
            PH_LEN: begin
                n_obyte = word_byte(i_cmd.len, r_bidx);
                if (r_bidx == BIDX_LAST) begin
                    n_bidx = '0;
                    if (i_cmd.dvalid && (i_cmd.len != '0)) begin
                        n_phase = (w_np == '0) ? PH_HDR1 : PH_DATA;
                    end else begin
                        w_done = 1'b1;
                    end
                end else begin
                    n_bidx = r_bidx + 1'b1;
                end
            end
            PH_HDR1: begin
                n_obyte = word_byte(r_msg_left, r_bidx);
                if (r_bidx == BIDX_LAST) begin
                    n_phase = PH_DATA;
                    n_bidx  = '0;
                end else begin
                    n_bidx = r_bidx + 1'b1;
                end
            end
            PH_DATA: begin
                n_obyte    = i_cmd.data;
                n_msg_left = r_msg_left - 1'b1;
                w_done     = 1'b1;
            end
            PH_REJ: begin
                n_ostat = 1'b1;
                w_done  = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
                w_done = 1'b1;
            end
        endcase

        if (w_done) begin
            n_phase = PH_IDLE;
        end

        n_pos   = (w_emit && !n_ostat) ? w_np : r_pos;
        n_oend  = !n_ostat && w_blk_end;
        n_olast = w_done;
    end

    assign o_cmd_pop = w_go && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bidx     <= '0;
            r_pos      <= '0;
            r_msg_left <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (w_go) begin
                r_phase    <= n_phase;
                r_bidx     <= n_bidx;
                r_pos      <= n_pos;
                r_msg_left <= n_msg_left;
            end
            if (w_slot_free) begin
                r_ovalid <= w_go && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free) begin
            r_obyte <= n_obyte;
            r_oend  <= n_oend;
            r_ostat <= n_ostat;
            r_olast <= n_olast;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_out_end    = r_oend;
    assign o_out_status = r_ostat;
    assign o_out_last   = r_olast;

endmodule

`default_nettype wire

FILE: rtl/message_block_framer_core.sv
// ----------------------------------------------------------------------------
// Message block framer - top level
// Packs length-prefixed messages into fixed-length blocks and streams the
// block bytes; oversized messages are reported and their bytes dropped.
// ----------------------------------------------------------------------------
// Throughput: the back end emits one byte per cycle unless the output stalls,
//   which sets the rate. A data byte is preceded by a block header if it opens
//   a block. A message start emits up to 4 padding bytes, a block header if it
//   opens a block, its length word and then any data byte carried with it.
// Reset: synchronous, active low; clears position, outstanding count, queue and
//   output register; config returns to block_len 1024, max_msg_len 1016.
`default_nettype none

module message_block_framer_core
    import msgbf_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_addr,     // 0 block_len, 1 max_msg_len
    input  wire logic [BLEN_W-1:0] i_cfg_data,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [23:0]       s_tdata,        // msg_len[15:0], data_byte[23:16]
    input  wire logic [1:0]        s_tuser,        // starts_message[0], data_valid[1]
    // output stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,        // block_byte[7:0]
    output logic                   m_tlast,        // block_end
    output logic [1:0]             m_tuser         // status[0], last[1]
);

    // Configuration: to be written only while the block is idle (the block does not
    // enforce this), so it is read directly by both front and back end.
    logic [BLEN_W-1:0] r_block_len;
    logic [MLEN_W-1:0] r_max_msg_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len   <= BLOCK_LEN_RST;
            r_max_msg_len <= MAX_MSG_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_BLOCK_LEN: r_block_len   <= i_cfg_data;
                CFG_MAX_MSG:   r_max_msg_len <= i_cfg_data[MLEN_W-1:0];
                default:       r_block_len   <= r_block_len;
            endcase
        end
    end

    // Front end: length check and classification of each transaction.
    logic w_push;
    logic w_full;
    t_cmd w_in_cmd;

    msgbf_front u_front (
        .i_s_valid     (s_tvalid),
        .o_s_ready     (s_tready),
        .i_s_data      (s_tdata),
        .i_s_user      (s_tuser),
        .i_max_msg_len (r_max_msg_len),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_cmd         (w_in_cmd)
    );

    // Command queue decouples input stalls from output stalls.
    logic w_cmd_valid;
    logic w_pop;
    t_cmd w_head;

    msgbf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_valid (w_cmd_valid)
    );

    // Back end: block framing, one byte per cycle unless the output stalls.
    msgbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_block_len  (r_block_len),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_head),
        .o_cmd_pop    (w_pop),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_out_byte   (m_tdata),
        .o_out_end    (m_tlast),
        .o_out_status (m_tuser[0]),
        .o_out_last   (m_tuser[1])
    );

    // A command leaves the queue only while one is there.
    a_pop_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_valid)
        else $error("command popped from empty queue");

    // A rejection is a single result: last set, no block end, zero byte.
    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[1] && !m_tlast && (m_tdata == 8'd0)))
        else $error("malformed rejection result");

    // Input is refused only while the queue is full.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> w_full)
        else $error("input stalled with queue space left");

endmodule

`default_nettype wire

FILE: tb/message_block_framer_core_tb.sv
// ----------------------------------------------------------------------------
// Message block framer - testbench
// Streams message starts and data bytes into the framer, predicts every block
// byte and rejection on the fly and checks each output transaction against
// the oldest prediction. Directed cases first, then random traffic over
// several block and message length limits, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module message_block_framer_core_tb;
    import msgbf_pkg::*;

    localparam int SETTLE_CYCLES = 16;     // pipeline flush for items without output
    localparam int MAX_REPORTS   = 10;

    // one output transaction as the framer should produce it
    typedef struct packed {
        logic [BYTE_W-1:0] blk_byte;
        logic              blk_end;
        logic              rejected;
        logic              last_of_item;
    } t_blk_out;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_addr  = CFG_BLOCK_LEN;
    logic [BLEN_W-1:0] i_cfg_data  = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata     = '0;    // msg_len[15:0], data_byte[23:16]
    logic [1:0]        s_tuser     = '0;    // starts_message[0], data_valid[1]
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [7:0]        m_tdata;             // block_byte[7:0]
    logic              m_tlast;             // block_end
    logic [1:0]        m_tuser;             // status[0], last[1]

    // framer state as the testbench tracks it
    logic [BLEN_W-1:0] cfg_block_len = BLOCK_LEN_RST;
    logic [MLEN_W-1:0] cfg_max_len   = MAX_MSG_RST;
    logic [BLEN_W-1:0] frame_pos     = '0;
    logic [MLEN_W-1:0] msg_left      = '0;
    logic              dropping      = 1'b0;

    t_blk_out block_q[$];       // block bytes and rejections still to come out
    int       item_res_cnt;
    int       mismatch_cnt = 0;
    bit       steady_flow  = 1'b0;  // no idling on either side once set
    int       stall_left   = 0;

    always #4 i_clk = ~i_clk;

    message_block_framer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Framing predictor
    // ------------------------------------------------------------------------
    // block lengths below the minimum behave as the minimum
    function automatic int unsigned eff_block_len();
        return (cfg_block_len < BLEN_W'(MIN_BLOCK)) ? 32'(MIN_BLOCK) : 32'(cfg_block_len);
    endfunction

    // one byte into the block; the byte that fills it closes it
    function automatic void emit_byte(input logic [7:0] b);
        logic closes;
        closes = (32'(frame_pos) + 1 >= eff_block_len());
        block_q.push_back('{blk_byte: b, blk_end: closes, rejected: 1'b0,
                            last_of_item: 1'b0});
        item_res_cnt++;
        frame_pos = closes ? '0 : frame_pos + 1'b1;
    endfunction

    // 32-bit word, little endian
    function automatic void emit_word(input logic [31:0] w);
        for (int i = 0; i < WORD_BYTES; i++)
            emit_byte(w[8*i +: 8]);
    endfunction

    // a fresh block opens with the count of carried-over message bytes
    function automatic void open_block(input logic [31:0] carry);
        if (frame_pos == 0)
            emit_word(carry);
    endfunction

    function automatic void emit_data(input logic [7:0] b);
        open_block(32'(msg_left));
        emit_byte(b);
        msg_left = msg_left - 1'b1;
    endfunction

    // push all output transactions caused by one input transaction
    function automatic int frame_item(input logic starts, input logic [15:0] len,
                                      input logic dv, input logic [7:0] b);
        int unsigned room;
        t_blk_out    tail;
        item_res_cnt = 0;
        if (starts) begin
            // a new start abandons whatever message was still open
            msg_left = '0;
            if (len > cfg_max_len) begin
                dropping = 1'b1;
                block_q.push_back('{blk_byte: '0, blk_end: 1'b0, rejected: 1'b1,
                                    last_of_item: 1'b0});
                item_res_cnt = 1;
            end else begin
                dropping = 1'b0;
                if (frame_pos != 0) begin
                    room = (eff_block_len() > 32'(frame_pos)) ?
                           eff_block_len() - 32'(frame_pos) : 0;
                    // too little room for a length word plus a byte: pad out
                    if (room < MIN_ROOM)
                        while (frame_pos != 0)
                            emit_byte(8'h00);
                end
                open_block(32'h0);
                emit_word(32'(len));
                msg_left = len;
                if (dv && msg_left != 0)
                    emit_data(b);
            end
        end else if (dv && !dropping && msg_left != 0) begin
            emit_data(b);
        end
        if (item_res_cnt != 0) begin
            tail = block_q.pop_back();
            tail.last_of_item = 1'b1;
            block_q.push_back(tail);
        end
        return item_res_cnt;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // one input transaction, with an occasional idle burst ahead of it
    task automatic send_item(input logic starts, input logic [15:0] len, input logic dv,
                             input logic [7:0] b, output int produced);
        if (!steady_flow && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, len};
        s_tuser  <= {dv, starts};
        do @(posedge i_clk); while (!s_tready);
        produced = frame_item(starts, len, dv, b);
    endtask

    // all output seen, then room for items that produce nothing
    task automatic drain();
        s_tvalid <= 1'b0;
        while (block_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both registers, back to back, valid held high between them
    task automatic program_regs(input logic [BLEN_W-1:0] blen, input logic [MLEN_W-1:0] mlen);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= CFG_BLOCK_LEN;
        i_cfg_data  <= blen;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_block_len = blen;
        i_cfg_addr <= CFG_MAX_MSG;
        i_cfg_data <= {1'b0, mlen};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_max_len = mlen;
        i_cfg_valid <= 1'b0;
    endtask

    // reset settings: first block header, empty message, start without data,
    // stray and non-data items, byte extremes
    task automatic test_framing();
        int got;
        send_item(1'b1, 16'd2, 1'b1, 8'h00, got);
        send_item(1'b0, 16'hFFFF, 1'b1, 8'hFF, got);
        send_item(1'b0, 16'h0000, 1'b1, 8'h5A, got);     // nothing outstanding
        send_item(1'b1, 16'd0, 1'b1, 8'hFF, got);        // byte on empty start ignored
        send_item(1'b1, 16'd1, 1'b0, 8'h00, got);        // framing bytes only
        send_item(1'b0, 16'h0000, 1'b0, 8'hAA, got);     // no data
        send_item(1'b0, 16'h0000, 1'b1, 8'h80, got);
    endtask

    // oversized start, its bytes dropped, then a start right at the limit
    task automatic test_rejection();
        int got;
        send_item(1'b1, 16'(MAX_MSG_RST) + 16'd1, 1'b1, 8'h11, got);
        send_item(1'b0, 16'h0000, 1'b1, 8'h33, got);
        send_item(1'b1, 16'(MAX_MSG_RST), 1'b0, 8'h00, got);
    endtask

    // block length cut below the current position mid-message, long
    // continuation, largest lengths, padding at a message start
    task automatic test_block_shrink();
        int got;
        program_regs(17'd65536, 16'd65528);
        send_item(1'b1, 16'd65528, 1'b1, 8'h3C, got);
        while (frame_pos < BLEN_W'(MIN_BLOCK))
            send_item(1'b0, 16'($urandom), 1'b1, 8'($urandom), got);
        // zero acts as the minimum; the position is already past it
        program_regs(17'd0, 16'd65528);
        send_item(1'b0, 16'($urandom), 1'b1, 8'hC3, got);
        while (frame_pos == 0 || eff_block_len() - 32'(frame_pos) >= MIN_ROOM)
            send_item(1'b0, 16'($urandom), 1'b1, 8'($urandom), got);
        send_item(1'b1, 16'hFFFF, 1'b1, 8'hE7, got);
        send_item(1'b1, 16'd1, 1'b1, 8'h7E, got);
    endtask

    // mostly well-formed messages with random content; the rest cut short,
    // oversized, stray bytes or random full-range lengths
    task automatic test_random_traffic(input int target, input logic [BLEN_W-1:0] blen,
                                       input logic [MLEN_W-1:0] mlen);
        int   made, got, len, cut, first, pick, k;
        logic dv;
        program_regs(blen, mlen);
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                len = ($urandom_range(0, 9) == 0) ?
                      $urandom_range(0, (mlen < 300) ? mlen : 300) :
                      $urandom_range(0, (mlen < 24) ? mlen : 24);
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
                dv  = (len == 0) ? 1'($urandom) : ($urandom_range(0, 7) != 0);
                first = (len != 0 && dv) ? 1 : 0;
                send_item(1'b1, 16'(len), dv, 8'($urandom), got);
                made += (got != 0);
                for (k = first; k < cut; k++) begin
                    if ($urandom_range(0, 15) == 0)
                        send_item(1'b0, 16'($urandom), 1'b0, 8'($urandom), got);
                    send_item(1'b0, 16'($urandom), 1'b1, 8'($urandom), got);
                    made += (got != 0);
                end
            end else if (pick < 16) begin
                send_item(1'b1, 16'($urandom_range(32'(mlen) + 1, 65535)), 1'($urandom),
                          8'($urandom), got);
                made += (got != 0);
                repeat ($urandom_range(0, 3))
                    send_item(1'b0, 16'($urandom), 1'b1, 8'($urandom), got);
            end else if (pick < 18) begin
                send_item(1'b0, 16'($urandom), 1'($urandom), 8'($urandom), got);
                made += (got != 0);
            end else begin
                send_item(1'b1, 16'($urandom), 1'($urandom), 8'($urandom), got);
                made += (got != 0);
                repeat ($urandom_range(0, 5)) begin
                    send_item(1'b0, 16'($urandom), 1'b1, 8'($urandom), got);
                    made += (got != 0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall bursts, none once the flow is steady
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 19) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // every output transaction against the oldest prediction
    always @(posedge i_clk) begin : check_blocks
        t_blk_out want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (block_q.size() == 0) begin
                if (mismatch_cnt < MAX_REPORTS)
                    $display("unexpected transaction: byte %02h end %0d status %0d last %0d",
                             m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
                mismatch_cnt++;
            end else begin
                want = block_q.pop_front();
                if (m_tdata !== want.blk_byte || m_tlast !== want.blk_end ||
                    m_tuser[0] !== want.rejected || m_tuser[1] !== want.last_of_item) begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display({"mismatch: byte %02h/%02h end %0d/%0d status %0d/%0d ",
                                  "last %0d/%0d (expected/actual)"},
                                 want.blk_byte, m_tdata, want.blk_end, m_tlast,
                                 want.rejected, m_tuser[0], want.last_of_item, m_tuser[1]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_framing();
        test_rejection();
        test_block_shrink();

        test_random_traffic(50, 17'd16, 16'd8);
        test_random_traffic(50, 17'd21, 16'd0);          // only empty messages pass
        test_random_traffic(60, 17'd7, 16'd40);          // below minimum block length
        test_random_traffic(50, 17'($urandom_range(16, 300)), 16'($urandom_range(0, 292)));
        test_random_traffic(50, 17'd65536, 16'd65528);
        steady_flow = 1'b1;
        test_random_traffic(60, BLOCK_LEN_RST, MAX_MSG_RST);

        drain();
        if (mismatch_cnt == 0 && block_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
